// ===== rtl/bsc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the bankers safety checker
// no dependencies
package bsc_pkg;

    localparam int unsigned DEF_PROCESSES  = 8;
    localparam int unsigned DEF_RESOURCES  = 8;
    localparam int unsigned DEF_COUNT_BITS = 8;

    localparam logic [3:0] CFG_RESET = 4'd8;

    // configuration register indexes
    localparam logic CFG_IDX_PROCESS  = 1'b0;
    localparam logic CFG_IDX_RESOURCE = 1'b1;

    // command codes
    localparam logic [2:0] CMD_ALLOC = 3'd0;
    localparam logic [2:0] CMD_MAX   = 3'd1;
    localparam logic [2:0] CMD_AVAIL = 3'd2;
    localparam logic [2:0] CMD_REQ   = 3'd3;
    localparam logic [2:0] CMD_CHECK = 3'd4;

    // result status codes
    localparam logic [2:0] ST_SAFE    = 3'd0;
    localparam logic [2:0] ST_UNSAFE  = 3'd1;
    localparam logic [2:0] ST_GRANTED = 3'd2;
    localparam logic [2:0] ST_EXCEED  = 3'd3;
    localparam logic [2:0] ST_WAIT    = 3'd4;
    localparam logic [2:0] ST_DENIED  = 3'd5;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] process;
        logic [2:0] resource;
        logic [7:0] amount;
        logic       last;
    } t_bsc_in;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] seq_process;
        logic       last_res;
    } t_bsc_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REQ_RD,
        S_REQ_EV,
        S_INIT,
        S_ROW,
        S_CHK_RD,
        S_CHK_EV,
        S_REL_RD,
        S_REL_EV,
        S_COM_RD,
        S_COM_WR,
        S_EMIT,
        S_ONE
    } t_bsc_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_REQ_RD,
        OP_REQ_EV,
        OP_INIT,
        OP_ROW_SKIP,
        OP_PASS,
        OP_CHK_RD,
        OP_CHK_EV,
        OP_REL_RD,
        OP_REL_EV,
        OP_COM_RD,
        OP_COM_WR,
        OP_EMIT_SEQ,
        OP_EMIT_ONE
    } t_bsc_op;

    typedef struct packed {
        t_bsc_op    op;
        logic [2:0] code;
    } t_bsc_ctl;

    typedef struct packed {
        logic p_bad;
        logic exceed;
        logic must_wait;
        logic col_last;
        logic chk_fail;
        logic row_done;
        logic row_finished;
        logic all_done;
        logic progress;
        logic trial;
        logic emit_last;
    } t_bsc_stat;

endpackage

// ===== rtl/bankers_safety_checker_core.sv =====
`timescale 1ns / 1ps
// table, available and non-final request writes give no result.
// final request: claim check with a read and an evaluate step per resource, work set-up, sweep.
// sweep: up to np passes; a row visit reads and evaluates its elements until one fails,
// a fitting row then reads and releases each resource; a grant reads and writes back each resource.
// throughput: one request at a time, results at one per cycle, next request taken
// in the cycle the final result is out. reset: counts return to 8, tables undefined.
module bankers_safety_checker_core #(
    parameter int PROCESSES  = bsc_pkg::DEF_PROCESSES,
    parameter int RESOURCES  = bsc_pkg::DEF_RESOURCES,
    parameter int COUNT_BITS = bsc_pkg::DEF_COUNT_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               start,
    input  bsc_pkg::t_bsc_in   i_req,
    output logic               busy,
    // configuration writes, only while idle
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [3:0]         i_cfg_data,
    // result strobe, cannot be held off
    output logic               o_valid,
    output bsc_pkg::t_bsc_out  o_res
);
    bsc_pkg::t_bsc_ctl  ctl;
    bsc_pkg::t_bsc_stat st;
    logic               accept;

    // a request is taken only while the sequencer is idle
    assign accept = start && !busy;

    bsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .i_st     (st),
        .o_ctl    (ctl),
        .o_busy   (busy)
    );

    // tables, work vector and result register
    bsc_dpath #(
        .PROCESSES  (PROCESSES),
        .RESOURCES  (RESOURCES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (ctl),
        .o_st       (st),
        .o_valid    (o_valid),
        .o_res      (o_res)
    );
endmodule

// ===== rtl/bsc_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies
module bsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/bsc_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer for request checks, safety sweeps, commit and result output
// depends on bsc_pkg
module bsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  bsc_pkg::t_bsc_in    i_req,
    input  bsc_pkg::t_bsc_stat  i_st,
    output bsc_pkg::t_bsc_ctl   o_ctl,
    output logic                o_busy
);
    bsc_pkg::t_bsc_state r_state, n_state;
    logic [2:0]          r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsc_pkg::S_IDLE;
            r_code  <= bsc_pkg::ST_SAFE;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        case (r_state)
            bsc_pkg::S_IDLE: begin
                if (i_accept && i_req.cmd == bsc_pkg::CMD_REQ && i_req.last) begin
                    n_state = bsc_pkg::S_REQ_RD;
                end else if (i_accept && i_req.cmd == bsc_pkg::CMD_CHECK) begin
                    n_state = bsc_pkg::S_INIT;
                end
            end
            bsc_pkg::S_REQ_RD: begin
                if (i_st.p_bad) begin
                    n_state = bsc_pkg::S_ONE;
                    n_code  = bsc_pkg::ST_EXCEED;
                end else begin
                    n_state = bsc_pkg::S_REQ_EV;
                end
            end
            bsc_pkg::S_REQ_EV: begin
                if (!i_st.col_last) begin
                    n_state = bsc_pkg::S_REQ_RD;
                end else if (i_st.exceed) begin
                    n_state = bsc_pkg::S_ONE;
                    n_code  = bsc_pkg::ST_EXCEED;
                end else if (i_st.must_wait) begin
                    n_state = bsc_pkg::S_ONE;
                    n_code  = bsc_pkg::ST_WAIT;
                end else begin
                    n_state = bsc_pkg::S_INIT;
                end
            end
            bsc_pkg::S_INIT: begin
                n_state = bsc_pkg::S_ROW;
            end
            bsc_pkg::S_ROW: begin
                if (i_st.row_done) begin
                    if (i_st.all_done) begin
                        if (i_st.trial) begin
                            n_state = bsc_pkg::S_COM_RD;
                        end else begin
                            n_state = bsc_pkg::S_EMIT;
                            n_code  = bsc_pkg::ST_SAFE;
                        end
                    end else if (!i_st.progress) begin
                        n_state = bsc_pkg::S_ONE;
                        n_code  = i_st.trial ? bsc_pkg::ST_DENIED : bsc_pkg::ST_UNSAFE;
                    end
                end else if (!i_st.row_finished) begin
                    n_state = bsc_pkg::S_CHK_RD;
                end
            end
            bsc_pkg::S_CHK_RD: begin
                n_state = bsc_pkg::S_CHK_EV;
            end
            bsc_pkg::S_CHK_EV: begin
                if (i_st.chk_fail) begin
                    n_state = bsc_pkg::S_ROW;
                end else if (i_st.col_last) begin
                    n_state = bsc_pkg::S_REL_RD;
                end else begin
                    n_state = bsc_pkg::S_CHK_RD;
                end
            end
            bsc_pkg::S_REL_RD: begin
                n_state = bsc_pkg::S_REL_EV;
            end
            bsc_pkg::S_REL_EV: begin
                n_state = i_st.col_last ? bsc_pkg::S_ROW : bsc_pkg::S_REL_RD;
            end
            bsc_pkg::S_COM_RD: begin
                n_state = bsc_pkg::S_COM_WR;
            end
            bsc_pkg::S_COM_WR: begin
                if (i_st.col_last) begin
                    n_state = bsc_pkg::S_EMIT;
                    n_code  = bsc_pkg::ST_GRANTED;
                end else begin
                    n_state = bsc_pkg::S_COM_RD;
                end
            end
            bsc_pkg::S_EMIT: begin
                if (i_st.emit_last) begin
                    n_state = bsc_pkg::S_IDLE;
                end
            end
            bsc_pkg::S_ONE: begin
                n_state = bsc_pkg::S_IDLE;
            end
            default: begin
                n_state = bsc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctl.code = r_code;
        o_ctl.op   = bsc_pkg::OP_NONE;
        case (r_state)
            bsc_pkg::S_REQ_RD: o_ctl.op = bsc_pkg::OP_REQ_RD;
            bsc_pkg::S_REQ_EV: o_ctl.op = bsc_pkg::OP_REQ_EV;
            bsc_pkg::S_INIT:   o_ctl.op = bsc_pkg::OP_INIT;
            bsc_pkg::S_ROW: begin
                if (i_st.row_done) begin
                    if (!i_st.all_done && i_st.progress) begin
                        o_ctl.op = bsc_pkg::OP_PASS;
                    end
                end else if (i_st.row_finished) begin
                    o_ctl.op = bsc_pkg::OP_ROW_SKIP;
                end
            end
            bsc_pkg::S_CHK_RD: o_ctl.op = bsc_pkg::OP_CHK_RD;
            bsc_pkg::S_CHK_EV: o_ctl.op = bsc_pkg::OP_CHK_EV;
            bsc_pkg::S_REL_RD: o_ctl.op = bsc_pkg::OP_REL_RD;
            bsc_pkg::S_REL_EV: o_ctl.op = bsc_pkg::OP_REL_EV;
            bsc_pkg::S_COM_RD: o_ctl.op = bsc_pkg::OP_COM_RD;
            bsc_pkg::S_COM_WR: o_ctl.op = bsc_pkg::OP_COM_WR;
            bsc_pkg::S_EMIT:   o_ctl.op = bsc_pkg::OP_EMIT_SEQ;
            bsc_pkg::S_ONE:    o_ctl.op = bsc_pkg::OP_EMIT_ONE;
            default:           o_ctl.op = bsc_pkg::OP_NONE;
        endcase
    end

    assign o_busy = (r_state != bsc_pkg::S_IDLE);
endmodule

// ===== rtl/bsc_dpath.sv =====
`timescale 1ns / 1ps
// tables, work vector, sweep counters, compares and result register
// depends on bsc_pkg and bsc_ram
module bsc_dpath #(
    parameter int PROCESSES  = bsc_pkg::DEF_PROCESSES,
    parameter int RESOURCES  = bsc_pkg::DEF_RESOURCES,
    parameter int COUNT_BITS = bsc_pkg::DEF_COUNT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  bsc_pkg::t_bsc_in    i_req,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [3:0]          i_cfg_data,
    input  bsc_pkg::t_bsc_ctl   i_ctl,
    output bsc_pkg::t_bsc_stat  o_st,
    output logic                o_valid,
    output bsc_pkg::t_bsc_out   o_res
);
    localparam int CB    = COUNT_BITS;
    localparam int PB    = $clog2(PROCESSES);
    localparam int RB    = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int CW    = $clog2(PROCESSES + 1);
    localparam int RCW   = $clog2(RESOURCES + 1);
    localparam int WB    = COUNT_BITS + $clog2(PROCESSES + 1);
    localparam int AW    = PB + RB;
    localparam int DEPTH = PROCESSES * (2 ** RB);

    logic [3:0]     r_pcount, r_rcount;
    logic [CW-1:0]  np;
    logic [RCW-1:0] nr;

    logic [2:0]     r_p;
    logic           r_trial, r_prog, r_exc, r_wait, r_valid;
    logic [CW-1:0]  r_i, r_count, r_k;
    logic [RB-1:0]  r_j;
    logic [PROCESSES-1:0] r_fin;

    logic [CB-1:0]  r_avail [RESOURCES];
    logic [CB-1:0]  r_reqb  [RESOURCES];
    logic [WB-1:0]  r_work  [RESOURCES];
    logic [PB-1:0]  r_seq   [PROCESSES];
    bsc_pkg::t_bsc_out r_out;

    logic [CB-1:0]  amt, alloc_q, max_q, req_j, avail_j;
    logic [WB-1:0]  work_j;
    logic [PB-1:0]  p_row, i_row;
    logic [CB:0]    talloc;
    logic           in_rng, res_rng, is_p_row, exceed_now, wait_now, chk_fail, col_last;
    logic           emit_last;
    logic           alloc_we, max_we;
    logic [AW-1:0]  rd_addr, in_addr, alloc_waddr;
    logic [CB-1:0]  alloc_wdata;

    assign np = (r_pcount == 4'd0) ? CW'(1) :
                ((int'(r_pcount) > PROCESSES) ? CW'(PROCESSES) : CW'(r_pcount));
    assign nr = (r_rcount == 4'd0) ? RCW'(1) :
                ((int'(r_rcount) > RESOURCES) ? RCW'(RESOURCES) : RCW'(r_rcount));

    assign amt     = CB'(i_req.amount);
    assign p_row   = PB'(r_p);
    assign i_row   = r_i[PB-1:0];
    assign req_j   = r_reqb[r_j];
    assign avail_j = r_avail[r_j];
    assign work_j  = r_work[r_j];
    assign in_rng  = (int'(i_req.process) < PROCESSES) && res_rng;
    assign res_rng = int'(i_req.resource) < RESOURCES;
    assign in_addr = {PB'(i_req.process), RB'(i_req.resource)};

    // the requesting row carries the granted units during a trial sweep
    assign is_p_row   = int'(r_i) == int'(r_p);
    assign talloc     = {1'b0, alloc_q} + ((r_trial && is_p_row) ? {1'b0, req_j} : '0);
    assign exceed_now = ({1'b0, req_j} + {1'b0, alloc_q}) > {1'b0, max_q};
    assign wait_now   = req_j > avail_j;
    assign chk_fail   = (WB + 1)'(max_q) > ((WB + 1)'(work_j) + (WB + 1)'(talloc));
    assign col_last   = (RCW'(r_j) + RCW'(1)) == nr;
    assign emit_last  = (r_k + CW'(1)) == np;

    assign rd_addr = (i_ctl.op == bsc_pkg::OP_CHK_RD || i_ctl.op == bsc_pkg::OP_REL_RD) ?
                     {i_row, r_j} : {p_row, r_j};

    assign alloc_we    = (i_accept && i_req.cmd == bsc_pkg::CMD_ALLOC && in_rng) ||
                         (i_ctl.op == bsc_pkg::OP_COM_WR);
    assign alloc_waddr = (i_ctl.op == bsc_pkg::OP_COM_WR) ? {p_row, r_j} : in_addr;
    assign alloc_wdata = (i_ctl.op == bsc_pkg::OP_COM_WR) ? (alloc_q + req_j) : amt;
    assign max_we      = i_accept && i_req.cmd == bsc_pkg::CMD_MAX && in_rng;

    bsc_ram #(.WIDTH(CB), .DEPTH(DEPTH)) u_alloc (
        .i_clk   (i_clk),
        .i_we    (alloc_we),
        .i_waddr (alloc_waddr),
        .i_wdata (alloc_wdata),
        .i_raddr (rd_addr),
        .o_rdata (alloc_q)
    );

    bsc_ram #(.WIDTH(CB), .DEPTH(DEPTH)) u_max (
        .i_clk   (i_clk),
        .i_we    (max_we),
        .i_waddr (in_addr),
        .i_wdata (amt),
        .i_raddr (rd_addr),
        .o_rdata (max_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= bsc_pkg::CFG_RESET;
            r_rcount <= bsc_pkg::CFG_RESET;
            r_trial  <= 1'b0;
            r_prog   <= 1'b0;
            r_exc    <= 1'b0;
            r_wait   <= 1'b0;
            r_valid  <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_count  <= '0;
            r_k      <= '0;
            r_fin    <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == bsc_pkg::CFG_IDX_PROCESS) begin
                    r_pcount <= i_cfg_data;
                end else begin
                    r_rcount <= i_cfg_data;
                end
            end
            if (i_accept) begin
                r_j     <= '0;
                r_k     <= '0;
                r_exc   <= 1'b0;
                r_wait  <= 1'b0;
                r_trial <= (i_req.cmd == bsc_pkg::CMD_REQ);
            end
            case (i_ctl.op)
                bsc_pkg::OP_REQ_EV: begin
                    r_exc  <= r_exc | exceed_now;
                    r_wait <= r_wait | wait_now;
                    r_j    <= col_last ? '0 : r_j + RB'(1);
                end
                bsc_pkg::OP_INIT: begin
                    r_i     <= '0;
                    r_j     <= '0;
                    r_count <= '0;
                    r_fin   <= '0;
                    r_prog  <= 1'b0;
                end
                bsc_pkg::OP_ROW_SKIP: begin
                    r_i <= r_i + CW'(1);
                end
                bsc_pkg::OP_PASS: begin
                    r_i    <= '0;
                    r_prog <= 1'b0;
                end
                bsc_pkg::OP_CHK_EV: begin
                    if (chk_fail) begin
                        r_i <= r_i + CW'(1);
                        r_j <= '0;
                    end else begin
                        r_j <= col_last ? '0 : r_j + RB'(1);
                    end
                end
                bsc_pkg::OP_REL_EV: begin
                    if (col_last) begin
                        r_j          <= '0;
                        r_fin[i_row] <= 1'b1;
                        r_count      <= r_count + CW'(1);
                        r_prog       <= 1'b1;
                        r_i          <= r_i + CW'(1);
                    end else begin
                        r_j <= r_j + RB'(1);
                    end
                end
                bsc_pkg::OP_COM_WR: begin
                    r_j <= col_last ? '0 : r_j + RB'(1);
                end
                bsc_pkg::OP_EMIT_SEQ: begin
                    r_valid <= 1'b1;
                    r_k     <= r_k + CW'(1);
                end
                bsc_pkg::OP_EMIT_ONE: begin
                    r_valid <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_p <= i_req.process;
            if (i_req.cmd == bsc_pkg::CMD_AVAIL && res_rng) begin
                r_avail[RB'(i_req.resource)] <= amt;
            end
            if (i_req.cmd == bsc_pkg::CMD_REQ && res_rng) begin
                r_reqb[RB'(i_req.resource)] <= amt;
            end
        end
        case (i_ctl.op)
            bsc_pkg::OP_INIT: begin
                for (int l = 0; l < RESOURCES; l++) begin
                    r_work[l] <= WB'(r_avail[l]) - (r_trial ? WB'(r_reqb[l]) : '0);
                end
            end
            bsc_pkg::OP_REL_EV: begin
                r_work[r_j] <= work_j + WB'(talloc);
                if (col_last) begin
                    r_seq[r_count[PB-1:0]] <= i_row;
                end
            end
            bsc_pkg::OP_COM_WR: begin
                r_avail[r_j] <= avail_j - req_j;
            end
            bsc_pkg::OP_EMIT_SEQ: begin
                r_out.status      <= i_ctl.code;
                r_out.seq_process <= 3'(r_seq[r_k[PB-1:0]]);
                r_out.last_res    <= emit_last;
            end
            bsc_pkg::OP_EMIT_ONE: begin
                r_out.status      <= i_ctl.code;
                r_out.seq_process <= (i_ctl.code == bsc_pkg::ST_UNSAFE) ? 3'd0 : r_p;
                r_out.last_res    <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_st.p_bad        = !(int'(r_p) < int'(np));
        o_st.exceed       = r_exc | exceed_now;
        o_st.must_wait    = r_wait | wait_now;
        o_st.col_last     = col_last;
        o_st.chk_fail     = chk_fail;
        o_st.row_done     = r_i >= np;
        o_st.row_finished = r_fin[i_row];
        o_st.all_done     = r_count == np;
        o_st.progress     = r_prog;
        o_st.trial        = r_trial;
        o_st.emit_last    = emit_last;
    end

    assign o_valid = r_valid;
    assign o_res   = r_out;

    a_chk_open_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == bsc_pkg::OP_CHK_RD) |-> !r_fin[i_row])
        else $error("row check started on a finished process");

    a_seq_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == bsc_pkg::OP_EMIT_SEQ && emit_last) |=> (r_valid && r_out.last_res))
        else $error("sequence end not flagged");

    a_commit_trial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == bsc_pkg::OP_COM_WR) |-> r_trial)
        else $error("commit outside a request");
endmodule

// ===== dv/bsc_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for the bankers safety checker: mirrors tables and counts, predicts results
// depends on bsc_pkg
module bsc_checker
    import bsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_bsc_in  i_req,
    input  logic     i_cfg_we,
    input  logic     i_cfg_idx,
    input  logic [3:0] i_cfg_data,
    input  logic     i_valid,
    input  t_bsc_out i_res,
    output int       o_errors,
    output int       o_pending
);

    int unsigned proc_cnt, res_cnt;
    int alloc_t[8][8];
    int max_t[8][8];
    int avail_v[8];
    int req_buf[8];
    int try_alloc[8][8];
    int try_avail[8];
    int work[8];
    int order[8];
    t_bsc_out outcome_q[$];

    function automatic int eff_count(int unsigned v);
        if (v == 0) return 1;
        return (v > 8) ? 8 : int'(v);
    endfunction

    // passes in index order, each fitting row releases its allocation into work
    function automatic bit sweep_safe(int np, int nr);
        int  count;
        int  need;
        bit  done[8];
        bit  progress;
        bit  fits;
        count = 0;
        for (int i = 0; i < 8; i++) done[i] = 1'b0;
        for (int j = 0; j < 8; j++) work[j] = (j < nr) ? try_avail[j] : 0;
        while (count < np) begin
            progress = 1'b0;
            for (int i = 0; i < np; i++) begin
                if (!done[i]) begin
                    fits = 1'b1;
                    for (int j = 0; j < nr; j++) begin
                        need = max_t[i][j] - try_alloc[i][j];
                        if (need > work[j]) fits = 1'b0;
                    end
                    if (fits) begin
                        for (int j = 0; j < nr; j++) work[j] += try_alloc[i][j];
                        order[count] = i;
                        count++;
                        done[i] = 1'b1;
                        progress = 1'b1;
                    end
                end
            end
            if (!progress) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void push_outcome(logic [2:0] st, int p, bit fin);
        t_bsc_out r;
        r.status      = st;
        r.seq_process = p[2:0];
        r.last_res    = fin;
        outcome_q.push_back(r);
    endfunction

    function automatic void predict(t_bsc_in it);
        int np, nr, p, r, amt;
        bit bad, short;
        np  = eff_count(proc_cnt);
        nr  = eff_count(res_cnt);
        p   = it.process;
        r   = it.resource;
        amt = it.amount;
        case (it.cmd)
            CMD_ALLOC: alloc_t[p][r] = amt;
            CMD_MAX:   max_t[p][r]   = amt;
            CMD_AVAIL: avail_v[r]    = amt;
            CMD_CHECK: begin
                try_alloc = alloc_t;
                try_avail = avail_v;
                if (sweep_safe(np, nr)) begin
                    for (int k = 0; k < np; k++) push_outcome(ST_SAFE, order[k], k == np - 1);
                end else begin
                    push_outcome(ST_UNSAFE, 0, 1'b1);
                end
            end
            CMD_REQ: begin
                req_buf[r] = amt;
                if (it.last) begin
                    bad   = (p >= np);
                    short = 1'b0;
                    for (int j = 0; j < nr; j++) begin
                        if (!bad && req_buf[j] > max_t[p][j] - alloc_t[p][j]) bad = 1'b1;
                        if (req_buf[j] > avail_v[j]) short = 1'b1;
                    end
                    if (bad) begin
                        push_outcome(ST_EXCEED, p, 1'b1);
                    end else if (short) begin
                        push_outcome(ST_WAIT, p, 1'b1);
                    end else begin
                        try_alloc = alloc_t;
                        try_avail = avail_v;
                        for (int j = 0; j < nr; j++) begin
                            try_alloc[p][j] = alloc_t[p][j] + req_buf[j];
                            try_avail[j]    = avail_v[j] - req_buf[j];
                        end
                        if (sweep_safe(np, nr)) begin
                            alloc_t = try_alloc;
                            avail_v = try_avail;
                            for (int k = 0; k < np; k++)
                                push_outcome(ST_GRANTED, order[k], k == np - 1);
                        end else begin
                            push_outcome(ST_DENIED, p, 1'b1);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_bsc_out want;
        if (!i_rst_n) begin
            proc_cnt = 8;
            res_cnt  = 8;
            outcome_q.delete();
            for (int i = 0; i < 8; i++) begin
                avail_v[i] = 0;
                req_buf[i] = 0;
                for (int j = 0; j < 8; j++) begin
                    alloc_t[i][j] = 0;
                    max_t[i][j]   = 0;
                end
            end
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_PROCESS) proc_cnt = i_cfg_data;
                else res_cnt = i_cfg_data;
            end
            if (i_start && !i_busy) predict(i_req);
            if (i_valid) begin
                if (outcome_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result st=%0d p=%0d last=%0d",
                                 i_res.status, i_res.seq_process, i_res.last_res);
                end else begin
                    want = outcome_q.pop_front();
                    if (want !== i_res) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch exp st=%0d p=%0d last=%0d got st=%0d p=%0d last=%0d",
                                     want.status, want.seq_process, want.last_res,
                                     i_res.status, i_res.seq_process, i_res.last_res);
                    end
                end
            end
        end
        o_pending = outcome_q.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// top of the bankers safety checker bench: clock, reset, request stimulus, verdict
// depends on bsc_pkg, bankers_safety_checker_core and bsc_checker
module tb;
    import bsc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    t_bsc_in    i_req = '0;
    logic       busy;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_idx = 1'b0;
    logic [3:0] i_cfg_data = 4'd0;
    logic       o_valid;
    t_bsc_out   o_res;
    int         errors;
    int         pending;
    int         cycles = 0;
    bit         gaps_on = 1'b1;
    // bench copy of the counts, used to shape well-formed request vectors
    int         np_used = 8;
    int         nr_used = 8;

    always #4 i_clk = ~i_clk;

    bankers_safety_checker_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req      (i_req),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_res      (o_res)
    );

    bsc_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (o_valid),
        .i_res      (o_res),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // watchdog on a hung handshake or a lost result
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // sender idle burst, start dropped for a span set by n
    task automatic idle(int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // one request, held until the block takes it; busy is stable at the falling edge
    task automatic send(logic [2:0] cmd, int p, int r, int amt, bit fin);
        t_bsc_in it;
        logic    was_busy;
        if (gaps_on && $urandom_range(0, 4) == 0) idle($urandom_range(1, 18));
        it.cmd      = cmd;
        it.process  = p[2:0];
        it.resource = r[2:0];
        it.amount   = amt[7:0];
        it.last     = fin;
        start <= 1'b1;
        i_req <= it;
        forever begin
            was_busy = busy;
            @(negedge i_clk);
            if (!was_busy) break;
        end
    endtask

    // hold off until every outstanding result has come and the block went quiet
    task automatic settle();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || busy) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_counts(int pc, int rc);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_PROCESS;
        i_cfg_data <= pc[3:0];
        @(negedge i_clk);
        i_cfg_idx  <= CFG_IDX_RESOURCE;
        i_cfg_data <= rc[3:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        np_used = (pc == 0) ? 1 : (pc > 8 ? 8 : pc);
        nr_used = (rc == 0) ? 1 : (rc > 8 ? 8 : rc);
    endtask

    // fill every table entry so no unwritten entry is ever read
    task automatic load_tables(int top);
        int mx;
        for (int p = 0; p < 8; p++) begin
            for (int r = 0; r < 8; r++) begin
                mx = $urandom_range(0, top);
                send(CMD_MAX, p, r, mx, 1'b0);
                send(CMD_ALLOC, p, r, $urandom_range(0, mx), 1'b0);
            end
        end
        for (int r = 0; r < 8; r++) send(CMD_AVAIL, 0, r, $urandom_range(0, top + 2), 1'b0);
    endtask

    // well-formed request vector over the resources in use
    task automatic request_vector(int p, int top);
        for (int r = 0; r < nr_used; r++)
            send(CMD_REQ, p, r, $urandom_range(0, top), r == nr_used - 1);
    endtask

    task automatic random_items(int n);
        int pick, p;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 19);
            p = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                             : $urandom_range(0, np_used - 1);
            if (pick < 11) begin
                request_vector(p, $urandom_range(0, 3));
            end else if (pick < 14) begin
                send(CMD_CHECK, $urandom_range(0, 7), $urandom_range(0, 7), $urandom, 1'b0);
            end else if (pick < 17) begin
                send(3'($urandom_range(0, 2)), $urandom_range(0, 7), $urandom_range(0, 7),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 6), 1'b0);
            end else if (pick < 19) begin
                // stray request element, may land beyond the resources in use
                send(CMD_REQ, p, $urandom_range(0, 7), $urandom_range(0, 4), $urandom_range(0, 1));
            end else begin
                send(3'($urandom_range(5, 7)), $urandom_range(0, 7), $urandom_range(0, 7),
                     $urandom, $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        int pc_set[6] = '{1, 0, 15, 3, 8, 0};
        int rc_set[6] = '{1, 3, 8, 0, 15, 0};

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: default counts, full tables first
        load_tables(6);
        for (int r = 0; r < 8; r++) send(CMD_REQ, 0, r, 0, 1'b0);
        send(CMD_CHECK, 0, 0, 0, 1'b0);
        request_vector(2, 1);
        // row 7 gets allocation above its claim, so its need goes negative
        send(CMD_ALLOC, 7, 7, 255, 1'b0);
        send(CMD_MAX, 0, 0, 255, 1'b0);
        send(CMD_AVAIL, 7, 7, 255, 1'b0);
        send(CMD_REQ, 7, 0, 1, 1'b1);
        send(CMD_CHECK, 7, 7, 255, 1'b1);
        // unused commands with all field bits high or all low
        send(3'd5, 7, 7, 255, 1'b1);
        send(3'd6, 0, 0, 0, 1'b0);
        send(3'd7, 7, 7, 255, 1'b1);
        // request of 255 units on resource 0 against the raised claim of row 0
        send(CMD_REQ, 0, 0, 255, 1'b1);
        // claim allows it but nothing is available
        send(CMD_MAX, 1, 0, 200, 1'b0);
        send(CMD_AVAIL, 0, 0, 0, 1'b0);
        send(CMD_REQ, 1, 0, 5, 1'b0);
        for (int r = 1; r < 8; r++) send(CMD_REQ, 1, r, 0, r == 7);
        send(CMD_CHECK, 0, 0, 0, 1'b0);

        // random phases over several count settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                gaps_on = 1'b0;
                write_counts($urandom_range(1, 8), $urandom_range(1, 8));
            end else begin
                write_counts(pc_set[ph], rc_set[ph]);
            end
            random_items(6);
        end

        settle();
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== bankers_safety_checker_core.f =====
rtl/bsc_pkg.sv
rtl/bsc_ram.sv
rtl/bsc_ctrl.sv
rtl/bsc_dpath.sv
rtl/bankers_safety_checker_core.sv
dv/bsc_checker.sv
dv/tb.sv
